FILE: src/iplpr_pkg.sv
// Shared types and constants for the IPv4 longest-prefix router.
// No dependencies; imported by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package iplpr_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int IFACE_W = 4;
  localparam int TTL_W   = 8;
  localparam int STAT_W  = 2;

  // request modes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_ROUTE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FWD   = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROP  = 2'd3;

  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // one stored route; mask is precomputed from the prefix length
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [LEN_W-1:0]   len;
    logic               has_gw;
    logic [ADDR_W-1:0]  gw;
    logic [IFACE_W-1:0] iface;
  } route_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic add_write;
    logic scan_read;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_mode;
    logic tbl_empty;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: src/iplpr_if.sv
// Request and result channel interfaces for the IPv4 longest-prefix router.
// Depends on iplpr_pkg for field widths.
`timescale 1ns / 1ps

interface iplpr_in_if import iplpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ADDR_W-1:0]   rt_prefix;
  logic [LEN_W-1:0]    prefix_len;
  logic                has_next_hop;
  logic [ADDR_W-1:0]   gateway_addr;
  logic [IFACE_W-1:0]  route_iface;
  logic [ADDR_W-1:0]   dest_addr;
  logic [TTL_W-1:0]    ttl_in;

  modport source (
    output valid, mode, rt_prefix, prefix_len, has_next_hop,
           gateway_addr, route_iface, dest_addr, ttl_in,
    input  ready
  );
  modport sink (
    input  valid, mode, rt_prefix, prefix_len, has_next_hop,
           gateway_addr, route_iface, dest_addr, ttl_in,
    output ready
  );
endinterface

interface iplpr_out_if import iplpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [IFACE_W-1:0]  out_iface;
  logic [ADDR_W-1:0]   hop_addr;
  logic [TTL_W-1:0]    ttl_out;

  modport source (
    output valid, status, out_iface, hop_addr, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_iface, hop_addr, ttl_out,
    output ready
  );
endinterface

FILE: src/ipv4_longest_prefix_router.sv
// Top level of the IPv4 longest-prefix router: controller plus datapath.
// Depends on iplpr_pkg, iplpr_if, iplpr_ctrl and iplpr_dp.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    mode, rt_prefix, prefix_len, has_next_hop,
//                                  gateway_addr, route_iface, dest_addr, ttl_in
//   out_ch    out   valid/ready    status, out_iface, hop_addr, ttl_out
//
// An add writes its entry to the table (unless full) and then loads the result;
// a route request scans the stored routes, reading one table entry per cycle,
// waits for the last compare and then loads the result (it goes straight to
// the result step when the table is empty). After the result is loaded the
// controller returns to idle and accepts the next request.
// Reset (synchronous, rst_n low) empties the table; no clearing pass.
// A new request is accepted while an earlier result still waits on out_ch;
// it stalls only at the result step until the result register is free.
`timescale 1ns / 1ps

module ipv4_longest_prefix_router import iplpr_pkg::*; #(
  parameter int TABLE_DEPTH = 32,
  parameter int NUM_IFACES  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  iplpr_in_if.sink    in_ch,
  iplpr_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  iplpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iplpr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_IFACES  (NUM_IFACES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_ch.mode),
    .in_rt_prefix    (in_ch.rt_prefix),
    .in_prefix_len   (in_ch.prefix_len),
    .in_has_next_hop (in_ch.has_next_hop),
    .in_gateway_addr (in_ch.gateway_addr),
    .in_route_iface  (in_ch.route_iface),
    .in_dest_addr    (in_ch.dest_addr),
    .in_ttl_in       (in_ch.ttl_in),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_iface       (out_ch.out_iface),
    .out_hop_addr    (out_ch.hop_addr),
    .out_ttl_out     (out_ch.ttl_out)
  );

endmodule

FILE: src/iplpr_ctrl.sv
// Controller state machine for the IPv4 longest-prefix router.
// Depends on iplpr_pkg; drives dp_cmd_t into iplpr_dp and reads dp_stat_t.
`timescale 1ns / 1ps

module iplpr_ctrl import iplpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_mode == MODE_ADD) begin
            state_nxt = S_ADD;
          end else if (stat.tbl_empty) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_ADD: begin
        state_nxt = S_RESULT;
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_ADD: begin
        cmd.add_write = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
      end
      S_DRAIN: begin
      end
      S_RESULT: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/iplpr_dp.sv
// Datapath for the IPv4 longest-prefix router: route memory, scan compare,
// best-match registers and the result register. Depends on iplpr_pkg.
`timescale 1ns / 1ps

module iplpr_dp import iplpr_pkg::*; #(
  parameter int TABLE_DEPTH = 32,
  parameter int NUM_IFACES  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               in_mode,
  input  logic [ADDR_W-1:0]  in_rt_prefix,
  input  logic [LEN_W-1:0]   in_prefix_len,
  input  logic               in_has_next_hop,
  input  logic [ADDR_W-1:0]  in_gateway_addr,
  input  logic [IFACE_W-1:0] in_route_iface,
  input  logic [ADDR_W-1:0]  in_dest_addr,
  input  logic [TTL_W-1:0]   in_ttl_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic [IFACE_W-1:0] out_iface,
  output logic [ADDR_W-1:0]  out_hop_addr,
  output logic [TTL_W-1:0]   out_ttl_out
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  route_ent_t mem [TABLE_DEPTH];

  // request registers
  logic               mode_r;
  logic [ADDR_W-1:0]  prefix_r;
  logic [LEN_W-1:0]   len_r;
  logic               has_gw_r;
  logic [ADDR_W-1:0]  gw_r;
  logic [IFACE_W-1:0] iface_r;
  logic [ADDR_W-1:0]  dest_r;
  logic [TTL_W-1:0]   ttl_r;

  // table and scan state
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   scan_idx_r;
  route_ent_t         rd_r;
  logic               rd_valid_r;
  logic               add_full_r;

  // best match so far
  logic               found_r;
  logic [LEN_W-1:0]   best_len_r;
  logic               best_has_gw_r;
  logic [ADDR_W-1:0]  best_gw_r;
  logic [IFACE_W-1:0] best_iface_r;

  // result register
  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r;
  logic [IFACE_W-1:0] oif_r;
  logic [ADDR_W-1:0]  hop_r;
  logic [TTL_W-1:0]   tout_r;

  logic               full;
  logic [LEN_W-1:0]   len_sat;
  route_ent_t         new_ent;
  logic               hit;
  logic               take;
  logic               fwd;
  logic [STAT_W-1:0]  res_status;
  logic [IFACE_W-1:0] res_oif;
  logic [ADDR_W-1:0]  res_hop;
  logic [TTL_W-1:0]   res_tout;

  assign full = (count_r == CNT_W'(TABLE_DEPTH));

  // build the entry: clamp length, precompute the compare mask
  always_comb begin
    len_sat        = (len_r > MAX_LEN) ? MAX_LEN : len_r;
    new_ent.prefix = prefix_r;
    new_ent.len    = len_sat;
    new_ent.mask   = (len_sat == '0) ? '0 : ({ADDR_W{1'b1}} << (MAX_LEN - len_sat));
    new_ent.has_gw = has_gw_r;
    new_ent.gw     = has_gw_r ? gw_r : '0;
    new_ent.iface  = iface_r;
  end

  // latch request fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= in_mode;
      prefix_r <= in_rt_prefix;
      len_r    <= in_prefix_len;
      has_gw_r <= in_has_next_hop;
      gw_r     <= in_gateway_addr;
      iface_r  <= in_route_iface;
      dest_r   <= in_dest_addr;
      ttl_r    <= in_ttl_in;
    end
  end

  // route memory: append on add, one registered read per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.add_write && !full) begin
      mem[count_r[IDX_W-1:0]] <= new_ent;
    end
    if (cmd.scan_read) begin
      rd_r <= mem[scan_idx_r];
    end
  end

  // route count, scan index, read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
      rd_valid_r <= 1'b0;
      add_full_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan_read;
      if (cmd.add_write) begin
        add_full_r <= full;
        if (!full) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.load_in) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_read) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  // compare the entry read last cycle; later equal length wins
  assign hit  = ((rd_r.prefix ^ dest_r) & rd_r.mask) == '0;
  assign take = rd_valid_r && hit && (!found_r || (best_len_r <= rd_r.len));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.load_in) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_len_r    <= rd_r.len;
      best_has_gw_r <= rd_r.has_gw;
      best_gw_r     <= rd_r.gw;
      best_iface_r  <= rd_r.iface;
    end
  end

  // form the result
  always_comb begin
    fwd        = found_r && (ttl_r > TTL_W'(1)) && (32'(best_iface_r) < 32'(NUM_IFACES));
    res_status = ST_DROP;
    res_oif    = '0;
    res_hop    = '0;
    res_tout   = '0;
    if (mode_r == MODE_ADD) begin
      res_status = add_full_r ? ST_FULL : ST_ADDED;
    end else if (fwd) begin
      res_status = ST_FWD;
      res_oif    = best_iface_r;
      res_hop    = best_has_gw_r ? best_gw_r : dest_r;
      res_tout   = ttl_r - TTL_W'(1);
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= res_status;
      oif_r    <= res_oif;
      hop_r    <= res_hop;
      tout_r   <= res_tout;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_iface    = oif_r;
  assign out_hop_addr = hop_r;
  assign out_ttl_out  = tout_r;

  // status to the controller
  always_comb begin
    stat.in_mode   = in_mode;
    stat.tbl_empty = (count_r == '0);
    stat.scan_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
    stat.out_busy  = out_valid_r && !out_ready;
  end

endmodule
